// ===== sv/iorb_pkg.sv =====
// Shared types and constants for the in-order result reorder buffer.
package iorb_pkg;

    localparam int SEQ_W  = 16;
    localparam int WORD_W = 32;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_FLUSH = 6'b001000,
        ST_READ  = 6'b010000,
        ST_CHECK = 6'b100000
    } state_t;

    // Result status codes.
    localparam logic STATUS_IN_ORDER = 1'b0;
    localparam logic STATUS_REJECT   = 1'b1;

    // Classification of an incoming sequence number.
    typedef struct packed {
        logic in_order;
        logic in_window;
    } dist_flags_t;

    // One result on its way to the output register.
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [WORD_W-1:0] main;
        logic [WORD_W-1:0] debug;
        logic              status;
        logic              last;
    } res_t;

endpackage

// ===== sv/iorb_slot_ram.sv =====
// Slot memory: one write port, one read port, registered read data.
module iorb_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 65
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/iorb_dist.sv =====
// Distance unit: classifies a sequence number and computes slot and pointer steps.
module iorb_dist #(
    parameter int WINDOW = 16
) (
    input  logic [iorb_pkg::SEQ_W-1:0]  seq,
    input  logic [iorb_pkg::SEQ_W-1:0]  next_exp,
    input  logic [$clog2(WINDOW)-1:0]   head,
    output iorb_pkg::dist_flags_t       flags,
    output logic [$clog2(WINDOW)-1:0]   slot_idx,
    output logic [$clog2(WINDOW)-1:0]   head_inc,
    output logic [iorb_pkg::SEQ_W-1:0]  seq_inc
);

    localparam int IDX_W = $clog2(WINDOW);

    logic [iorb_pkg::SEQ_W-1:0] seq_diff;
    logic [IDX_W:0]             slot_sum;

    always_comb begin
        seq_diff        = seq - next_exp;
        flags.in_order  = (seq_diff == '0);
        flags.in_window = (seq_diff < iorb_pkg::SEQ_W'(WINDOW));
        // head + seq_diff stays below twice the window: one compare and subtract
        slot_sum = {1'b0, head} + {1'b0, seq_diff[IDX_W-1:0]};
        if (slot_sum >= (IDX_W+1)'(WINDOW)) begin
            slot_sum = slot_sum - (IDX_W+1)'(WINDOW);
        end
        slot_idx = slot_sum[IDX_W-1:0];
        head_inc = (head == IDX_W'(WINDOW - 1)) ? '0 : head + 1'b1;
        seq_inc  = next_exp + 1'b1;
    end

endmodule

// ===== sv/iorb_ctrl.sv =====
// Sequencer: accepts one transaction, parks it or releases it and drains parked successors.
module iorb_ctrl #(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [iorb_pkg::SEQ_W-1:0]     in_seq,
    input  logic [iorb_pkg::WORD_W-1:0]    in_main,
    input  logic [iorb_pkg::WORD_W-1:0]    in_debug,
    output logic                           res_valid,
    input  logic                           res_ready,
    output iorb_pkg::res_t                 res
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int KEEP_W = (PAYLOAD_BITS < iorb_pkg::WORD_W) ? PAYLOAD_BITS
                                                              : iorb_pkg::WORD_W;
    localparam int ENT_W  = 1 + 2 * KEEP_W;

    iorb_pkg::state_t state_reg, state_next;

    logic [iorb_pkg::SEQ_W-1:0] next_exp_reg, next_exp_next;
    logic [IDX_W-1:0]           head_reg, head_next;
    logic [IDX_W-1:0]           clr_reg, clr_next;
    logic [iorb_pkg::SEQ_W-1:0] cur_seq_reg, cur_seq_next;
    logic [KEEP_W-1:0]          cur_main_reg, cur_main_next;
    logic [KEEP_W-1:0]          cur_dbg_reg, cur_dbg_next;
    logic                       cur_status_reg, cur_status_next;

    iorb_pkg::dist_flags_t      flags;
    logic [IDX_W-1:0]           slot_idx;
    logic [IDX_W-1:0]           head_inc;
    logic [iorb_pkg::SEQ_W-1:0] seq_inc;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [ENT_W-1:0]           ram_wdata;
    logic                       ram_re;
    logic [ENT_W-1:0]           ram_rdata;
    logic                       rd_valid;

    iorb_dist #(
        .WINDOW(WINDOW)
    ) u_dist (
        .seq      (cur_seq_reg),
        .next_exp (next_exp_reg),
        .head     (head_reg),
        .flags    (flags),
        .slot_idx (slot_idx),
        .head_inc (head_inc),
        .seq_inc  (seq_inc)
    );

    iorb_slot_ram #(
        .DEPTH(WINDOW),
        .WIDTH(ENT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // entry layout: {valid, main, debug}
    assign rd_valid = ram_rdata[ENT_W-1];
    assign in_ready = (state_reg == iorb_pkg::ST_IDLE);
    assign ram_re   = (state_reg == iorb_pkg::ST_READ);

    always_comb begin
        state_next      = state_reg;
        next_exp_next   = next_exp_reg;
        head_next       = head_reg;
        clr_next        = clr_reg;
        cur_seq_next    = cur_seq_reg;
        cur_main_next   = cur_main_reg;
        cur_dbg_next    = cur_dbg_reg;
        cur_status_next = cur_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = '0;
        res_valid       = 1'b0;
        res.seq         = cur_seq_reg;
        res.main        = '0;
        res.main[KEEP_W-1:0]  = cur_main_reg;
        res.debug       = '0;
        res.debug[KEEP_W-1:0] = cur_dbg_reg;
        res.status      = cur_status_reg;
        res.last        = 1'b1;

        case (state_reg)
            iorb_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(WINDOW - 1)) begin
                    state_next = iorb_pkg::ST_IDLE;
                end
            end
            iorb_pkg::ST_IDLE: begin
                if (in_valid) begin
                    cur_seq_next  = in_seq;
                    cur_main_next = in_main[KEEP_W-1:0];
                    cur_dbg_next  = in_debug[KEEP_W-1:0];
                    state_next    = iorb_pkg::ST_EVAL;
                end
            end
            iorb_pkg::ST_EVAL: begin
                if (flags.in_order) begin
                    cur_status_next = iorb_pkg::STATUS_IN_ORDER;
                    next_exp_next   = seq_inc;
                    head_next       = head_inc;
                    state_next      = iorb_pkg::ST_READ;
                end else if (flags.in_window) begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_idx;
                    ram_wdata  = {1'b1, cur_main_reg, cur_dbg_reg};
                    state_next = iorb_pkg::ST_IDLE;
                end else begin
                    cur_status_next = iorb_pkg::STATUS_REJECT;
                    state_next      = iorb_pkg::ST_FLUSH;
                end
            end
            iorb_pkg::ST_FLUSH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = iorb_pkg::ST_IDLE;
                end
            end
            iorb_pkg::ST_READ: begin
                state_next = iorb_pkg::ST_CHECK;
            end
            iorb_pkg::ST_CHECK: begin
                // the pending result is last unless the next slot holds a successor
                res_valid = 1'b1;
                res.last  = ~rd_valid;
                if (res_ready) begin
                    if (rd_valid) begin
                        ram_we          = 1'b1;
                        ram_waddr       = head_reg;
                        cur_seq_next    = next_exp_reg;
                        cur_main_next   = ram_rdata[2*KEEP_W-1:KEEP_W];
                        cur_dbg_next    = ram_rdata[KEEP_W-1:0];
                        cur_status_next = iorb_pkg::STATUS_IN_ORDER;
                        next_exp_next   = seq_inc;
                        head_next       = head_inc;
                        state_next      = iorb_pkg::ST_READ;
                    end else begin
                        state_next = iorb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = iorb_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= iorb_pkg::ST_CLEAR;
            next_exp_reg <= '0;
            head_reg     <= '0;
            clr_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            next_exp_reg <= next_exp_next;
            head_reg     <= head_next;
            clr_reg      <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_seq_reg    <= cur_seq_next;
        cur_main_reg   <= cur_main_next;
        cur_dbg_reg    <= cur_dbg_next;
        cur_status_reg <= cur_status_next;
    end

endmodule

// ===== sv/in_order_result_reorder_buffer.sv =====
// Top level of the in-order result reorder buffer: stream ports and output register.
//
// Results tagged with a 16-bit sequence number come in on the s_ side and leave on
// the m_ side strictly in sequence order. A number ahead of the expected one by less
// than WINDOW is parked and produces nothing; the expected number is released at once
// followed by every parked successor, the final one marked with m_tlast. Any other
// number comes back at once with m_tuser set (rejected), payloads echoed, m_tlast set.
// Payloads keep their low PAYLOAD_BITS bits (at most 32). After reset the slot memory
// is swept clear before s_tready rises. One transaction is handled at a time, and
// parked successors are drained one by one through the single read port of the slot
// memory; a full output register stalls the sequencer.
module in_order_result_reorder_buffer #(
    parameter int WINDOW       = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // seq_id[15:0], main_word[47:16], debug_word[79:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_seq[15:0], out_main[47:16], out_debug[79:48]
    output logic        m_tlast,
    output logic        m_tuser    // status: 0 released in order, 1 rejected
);

    logic           res_valid;
    logic           res_ready;
    iorb_pkg::res_t res;

    logic           out_valid_reg, out_valid_next;
    iorb_pkg::res_t out_reg;

    iorb_ctrl #(
        .WINDOW       (WINDOW),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_seq    (s_tdata[15:0]),
        .in_main   (s_tdata[47:16]),
        .in_debug  (s_tdata[79:48]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = ~out_valid_reg | m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.debug, out_reg.main, out_reg.seq};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;

endmodule

// ===== verif/in_order_result_reorder_buffer_tb.sv =====
// Self-checking testbench for the in-order result reorder buffer.
`timescale 1ns / 1ps

module in_order_result_reorder_buffer_tb;

    localparam int WINDOW       = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int HEAD_W       = $clog2(WINDOW);
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_ITEMS = 270;
    localparam int TAIL_ITEMS   = 30;
    localparam int MAX_LOGGED   = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // seq_id[15:0], main_word[47:16], debug_word[79:48]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // out_seq[15:0], out_main[47:16], out_debug[79:48]
    logic        m_tlast;
    logic        m_tuser;         // status

    in_order_result_reorder_buffer #(
        .WINDOW      (WINDOW),
        .PAYLOAD_BITS(PAYLOAD_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Predictor state
    logic [15:0]       next_seq;
    logic [HEAD_W-1:0] head_slot;
    logic              slot_full    [WINDOW];
    logic [31:0]       slot_main_w  [WINDOW];
    logic [31:0]       slot_debug_w [WINDOW];

    iorb_pkg::res_t release_q[$];
    iorb_pkg::res_t want;
    int   err_count   = 0;
    int   cycle_count = 0;
    int   sent_count  = 0;
    bit   no_idle     = 1'b0;

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Works out the results one accepted transaction causes and queues them.
    function automatic void predict_release(input logic [15:0] seq, input logic [31:0] mw,
                                            input logic [31:0] dw);
        logic [15:0]    seq_diff;
        iorb_pkg::res_t r;
        seq_diff = seq - next_seq;
        if (seq_diff == 16'd0) begin
            r.seq    = seq;
            r.main   = mw;
            r.debug  = dw;
            r.status = iorb_pkg::STATUS_IN_ORDER;
            next_seq  = next_seq + 16'd1;
            head_slot = head_slot + 1'b1;
            r.last    = !slot_full[head_slot];
            release_q.push_back(r);
            // drain the run of parked successors
            while (slot_full[head_slot]) begin
                r.seq    = next_seq;
                r.main   = slot_main_w[head_slot];
                r.debug  = slot_debug_w[head_slot];
                r.status = iorb_pkg::STATUS_IN_ORDER;
                slot_full[head_slot] = 1'b0;
                next_seq  = next_seq + 16'd1;
                head_slot = head_slot + 1'b1;
                r.last    = !slot_full[head_slot];
                release_q.push_back(r);
            end
        end else if (seq_diff < WINDOW) begin
            slot_full[head_slot + seq_diff[HEAD_W-1:0]]    = 1'b1;
            slot_main_w[head_slot + seq_diff[HEAD_W-1:0]]  = mw;
            slot_debug_w[head_slot + seq_diff[HEAD_W-1:0]] = dw;
        end else begin
            r.seq    = seq;
            r.main   = mw;
            r.debug  = dw;
            r.status = iorb_pkg::STATUS_REJECT;
            r.last   = 1'b1;
            release_q.push_back(r);
        end
    endfunction

    function automatic void check_field(input string field, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            if (err_count <= MAX_LOGGED)
                $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
        end
    endfunction

    // Presents one transaction and holds it until accepted.
    task automatic send_result(input logic [15:0] seq, input logic [31:0] mw,
                               input logic [31:0] dw);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tdata  <= {dw, mw, seq};
        s_tvalid <= 1'b1;
        predict_release(seq, mw, dw);
        sent_count++;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Shuffled run of consecutive numbers, with repeats and stray numbers mixed in.
    task automatic send_shuffled_run();
        logic [15:0] order [WINDOW];
        logic [15:0] tmp;
        logic [15:0] base;
        int          run_len;
        int          k;
        base    = next_seq;
        run_len = $urandom_range(1, WINDOW);
        for (int i = 0; i < run_len; i++) order[i] = base + 16'(i);
        for (int i = run_len - 1; i > 0; i--) begin
            k        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[k];
            order[k] = tmp;
        end
        for (int i = 0; i < run_len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    send_result(16'($urandom()), rand_word(), rand_word());
                else
                    send_result(next_seq + 16'($urandom_range(0, 40)), rand_word(),
                                rand_word());
            end
            if (i > 0 && $urandom_range(0, 11) == 0)
                send_result(order[$urandom_range(0, i - 1)], rand_word(), rand_word());
            send_result(order[i], rand_word(), rand_word());
        end
    endtask

    task automatic test_in_order_extremes();
        send_result(16'd0, 32'h0, 32'h0);
        send_result(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fill the whole window behind a gap, overwrite one slot, then release all 16.
    task automatic test_park_and_drain();
        for (int i = 1; i < WINDOW; i++)
            send_result(next_seq + 16'(i), rand_word(), rand_word());
        send_result(next_seq + 16'd5, 32'hA5A5_0001, 32'h5A5A_0002);
        send_result(next_seq, rand_word(), rand_word());
    endtask

    task automatic test_reject_and_edges();
        send_result(next_seq + 16'(WINDOW), rand_word(), rand_word());   // one past window
        send_result(next_seq - 16'd1, rand_word(), rand_word());         // already passed
        send_result(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_result(next_seq + 16'(WINDOW - 1), rand_word(), rand_word()); // far edge parks
        send_result(next_seq, rand_word(), rand_word());                   // lone release
    endtask

    task automatic test_random_traffic();
        int start_count;
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_ITEMS) send_shuffled_run();
    endtask

    task automatic test_back_to_back_tail();
        int start_count;
        no_idle     = 1'b1;
        start_count = sent_count;
        while (sent_count - start_count < TAIL_ITEMS) send_shuffled_run();
    endtask

    // Result side: random stall bursts, none in the tail.
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (!no_idle && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 17);
            end else begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 30);
            end
            repeat (n) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (release_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_LOGGED)
                    $error("result with nothing outstanding: out_seq 0x%0h", m_tdata[15:0]);
            end else begin
                want = release_q.pop_front();
                check_field("out_seq", 32'(want.seq), 32'(m_tdata[15:0]));
                check_field("out_main", want.main, m_tdata[47:16]);
                check_field("out_debug", want.debug, m_tdata[79:48]);
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        next_seq  = '0;
        head_slot = '0;
        for (int i = 0; i < WINDOW; i++) slot_full[i] = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_in_order_extremes();
        test_park_and_drain();
        test_reject_and_edges();
        test_random_traffic();
        test_back_to_back_tail();

        s_tvalid <= 1'b0;
        for (int i = 0; i < 20000 && release_q.size() != 0; i++) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (release_q.size() != 0) begin
            err_count++;
            $error("%0d expected results never arrived", release_q.size());
        end
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
